// ===== hw/rtl/hcc_pkg.sv =====
// shared constants and types of the hamming check and correct block
`timescale 1ns / 1ps

package hcc_pkg;

	// default data word width
	localparam int MAX_DATA_BITS_DEF = 15;

	// correction outcome codes
	typedef enum logic [1:0] {
		ST_NONE     = 2'd0,
		ST_FIXED    = 2'd1,
		ST_UNUSABLE = 2'd2
	} status_t;

endpackage

// ===== hw/rtl/hcc_syndrome.sv =====
// length clamp, data masking, parity trees and syndrome of one word
`timescale 1ns / 1ps

module hcc_syndrome #(
	parameter int MAX_DATA_BITS = hcc_pkg::MAX_DATA_BITS_DEF,
	localparam int LW = $clog2(MAX_DATA_BITS + 1),
	localparam int PW = LW
) (
	input  logic [MAX_DATA_BITS-1:0] data_in,
	input  logic [LW-1:0]            len_in,
	input  logic [PW-1:0]            rx_par,
	output logic [MAX_DATA_BITS-1:0] data_masked,
	output logic [LW-1:0]            len_sat,
	output logic [PW-1:0]            par,
	output logic                     all_par,
	output logic [PW-1:0]            syn
);

	logic [PW-1:0] used;

	always_comb begin
		len_sat = (len_in > LW'(MAX_DATA_BITS)) ? LW'(MAX_DATA_BITS) : len_in;
		for (int k = 0; k < MAX_DATA_BITS; k++) begin
			data_masked[k] = data_in[k] & (LW'(k) < len_sat);
		end
		all_par = ^data_masked;
		// positions beyond the length are masked, so unused powers come out zero
		for (int p = 0; p < PW; p++) begin
			par[p] = 1'b0;
			for (int k = 0; k < MAX_DATA_BITS; k++) begin
				if ((((k + 1) >> p) & 1) != 0) begin
					par[p] = par[p] ^ data_masked[k];
				end
			end
			used[p] = (LW'(1) << p) <= len_sat;
		end
		syn = (par ^ rx_par) & used;
	end

endmodule

// ===== hw/rtl/hcc_corrector.sv =====
// decides on the flip and applies it to the masked data
`timescale 1ns / 1ps

module hcc_corrector #(
	parameter int MAX_DATA_BITS = hcc_pkg::MAX_DATA_BITS_DEF,
	localparam int LW = $clog2(MAX_DATA_BITS + 1),
	localparam int PW = LW
) (
	input  logic [MAX_DATA_BITS-1:0] data_masked,
	input  logic [LW-1:0]            len_sat,
	input  logic [PW-1:0]            syn,
	input  logic                     mismatch,
	output logic [MAX_DATA_BITS-1:0] data_out,
	output hcc_pkg::status_t         status,
	output logic [LW-1:0]            flip_pos
);

	logic fix;

	always_comb begin
		fix      = 1'b0;
		status   = hcc_pkg::ST_NONE;
		flip_pos = '0;
		if (mismatch) begin
			// syndrome zero or past the length cannot name a data bit
			if (syn == '0 || syn > len_sat) begin
				status = hcc_pkg::ST_UNUSABLE;
			end else begin
				fix      = 1'b1;
				status   = hcc_pkg::ST_FIXED;
				flip_pos = syn;
			end
		end
		for (int k = 0; k < MAX_DATA_BITS; k++) begin
			data_out[k] = data_masked[k] ^ (fix && (syn == LW'(k + 1)));
		end
	end

endmodule

// ===== hw/rtl/hamming_check_and_correct.sv =====
// top level of the hamming single error check and correct block
`timescale 1ns / 1ps

// usage
//  input channel: drive the word fields and raise start; a beat is taken at
//  every rising edge where start is high and busy is low. busy is always low,
//  so a new word can be offered in every cycle
//  result channel: done is high for exactly one cycle, the result fields are
//  valid in that cycle only; the receiver cannot stall, so no result is held
//  a taken beat is held in the input register, then its result in the result
//  register, which drives done and the result fields
//  throughput: one word per cycle, set by the single pass of xor trees and
//  the flip decision between the two registers
//  reset: arst_n low clears the valid flags of both stages at once; no result
//  appears for beats that were in flight
//  lengths above MAX_DATA_BITS are clamped; data bits past the length are
//  zero in corrected_data, parity bits for unused powers are zero
module hamming_check_and_correct #(
	parameter int MAX_DATA_BITS = hcc_pkg::MAX_DATA_BITS_DEF,
	localparam int LW = $clog2(MAX_DATA_BITS + 1),
	localparam int PW = LW
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [MAX_DATA_BITS-1:0] data_bits,
	input  logic [LW-1:0]            data_length,
	input  logic [PW-1:0]            received_parity,
	input  logic                     received_overall,
	output logic                     done,
	output logic [PW-1:0]            computed_parity,
	output logic                     computed_overall,
	output logic [MAX_DATA_BITS-1:0] corrected_data,
	output logic [1:0]               correction_status,
	output logic [LW-1:0]            flipped_position
);

	// input stage
	logic                     valid_s1;
	logic [MAX_DATA_BITS-1:0] data_s1;
	logic [LW-1:0]            len_s1;
	logic [PW-1:0]            rx_par_s1;
	logic                     rx_all_s1;

	// combinational pass
	logic [MAX_DATA_BITS-1:0] data_masked;
	logic [LW-1:0]            len_sat;
	logic [PW-1:0]            par;
	logic                     all_par;
	logic [PW-1:0]            syn;
	logic [MAX_DATA_BITS-1:0] data_fixed;
	hcc_pkg::status_t         status;
	logic [LW-1:0]            flip_pos;

	// result stage
	logic                     done_s2;
	logic [PW-1:0]            par_s2;
	logic                     all_s2;
	logic [MAX_DATA_BITS-1:0] data_s2;
	hcc_pkg::status_t         status_s2;
	logic [LW-1:0]            flip_s2;

	// no internal backpressure, a beat is taken whenever start is high
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// payload capture only on an accepted beat
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			data_s1   <= data_bits;
			len_s1    <= data_length;
			rx_par_s1 <= received_parity;
			rx_all_s1 <= received_overall;
		end
	end

	hcc_syndrome #(
		.MAX_DATA_BITS(MAX_DATA_BITS)
	) u_syndrome (
		.data_in    (data_s1),
		.len_in     (len_s1),
		.rx_par     (rx_par_s1),
		.data_masked(data_masked),
		.len_sat    (len_sat),
		.par        (par),
		.all_par    (all_par),
		.syn        (syn)
	);

	// correction is attempted only when the overall parity disagrees
	hcc_corrector #(
		.MAX_DATA_BITS(MAX_DATA_BITS)
	) u_corrector (
		.data_masked(data_masked),
		.len_sat    (len_sat),
		.syn        (syn),
		.mismatch   (all_par != rx_all_s1),
		.data_out   (data_fixed),
		.status     (status),
		.flip_pos   (flip_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			par_s2    <= par;
			all_s2    <= all_par;
			data_s2   <= data_fixed;
			status_s2 <= status;
			flip_s2   <= flip_pos;
		end
	end

	assign done              = done_s2;
	assign computed_parity   = par_s2;
	assign computed_overall  = all_s2;
	assign corrected_data    = data_s2;
	assign correction_status = status_s2;
	assign flipped_position  = flip_s2;

	// every accepted beat yields a result after the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done)
		else $error("accepted beat produced no result");

	// a correction always names a position
	a_fix_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && correction_status == hcc_pkg::ST_FIXED |-> flipped_position != '0)
		else $error("correction without a position");

	// no correction means no position reported
	a_nofix_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && correction_status != hcc_pkg::ST_FIXED |-> flipped_position == '0)
		else $error("position reported without correction");

	// a correction requires the overall parity of the beat to disagree
	a_fix_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		done && correction_status == hcc_pkg::ST_FIXED
			|-> $past(received_overall, 2) != computed_overall)
		else $error("correction with matching overall parity");

endmodule
